// ===== src/leb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and key codes for the line editor buffer.
// No dependencies; imported by leb_seq and line_editor_buffer.
package leb_pkg;

    // Keystroke codes
    localparam logic [7:0] KEY_HOME     = 8'h01;
    localparam logic [7:0] KEY_LEFT     = 8'h02;
    localparam logic [7:0] KEY_EOF      = 8'h04;
    localparam logic [7:0] KEY_END      = 8'h05;
    localparam logic [7:0] KEY_RIGHT    = 8'h06;
    localparam logic [7:0] KEY_BS       = 8'h08;
    localparam logic [7:0] KEY_NL       = 8'h0A;
    localparam logic [7:0] KEY_KILL     = 8'h0B;
    localparam logic [7:0] KEY_DEL      = 8'h7F;
    localparam logic [7:0] KEY_PRINT_LO = 8'h20;
    localparam logic [7:0] KEY_PRINT_HI = 8'h7E;

    // Result kinds
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_BELL = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Register map (word index taken from paddr[2])
    localparam int unsigned RL_W                = 6;
    localparam logic        REG_RESERVED_LENGTH = 1'b0;

    typedef struct packed {
        logic [7:0] key;
        logic       end_of_input;
    } leb_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } leb_out_t;

endpackage

// ===== src/leb_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module leb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/leb_alu.sv =====
`timescale 1ns / 1ps
// Shared index unit: one adder and one equality compare on the sum.
// No dependencies; used by leb_seq for every walk over the text store.
module leb_alu #(
    parameter int unsigned W = 7
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] cmp_val,
    output logic [W-1:0] sum,
    output logic         sum_eq
);

    assign sum    = op_a + op_b;
    assign sum_eq = (sum == cmp_val);

endmodule

// ===== src/leb_seq.sv =====
`timescale 1ns / 1ps
// Edit sequencer: decodes keys, walks the text store through the shared index unit,
// and drives the registered result stage. Depends on leb_pkg, leb_ram and leb_alu.
module leb_seq #(
    parameter int unsigned LINE_LENGTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  leb_pkg::leb_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output leb_pkg::leb_out_t                    m_data,
    input  logic                                 cfg_clear,
    input  logic [$clog2(LINE_LENGTH+1)-1:0]     cap
);
    import leb_pkg::*;

    localparam int unsigned CW = $clog2(LINE_LENGTH + 1);
    localparam int unsigned AW = $clog2(LINE_LENGTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SR_RD, S_SR_WR, S_INS, S_EM_RD, S_EM_WR, S_TAIL, S_SL_RD, S_SL_WR
    } state_t;

    typedef enum logic [1:0] {OP_EOF, OP_NL, OP_CHUNK, OP_BELL} op_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    dist_reg, dist_next;
    logic [7:0]       key_reg, key_next;
    logic             m_valid_reg, m_valid_next;
    leb_out_t         m_data_reg, m_data_next;

    logic             out_load, out_free;
    logic [CW-1:0]    unit_b, unit_cmp, unit_sum;
    logic             unit_eq;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    logic [CW-1:0]    len_inc, chunk_rest;
    logic [7:0]       k;

    leb_alu #(.W(CW)) u_alu (
        .op_a    (idx_reg),
        .op_b    (unit_b),
        .cmp_val (unit_cmp),
        .sum     (unit_sum),
        .sum_eq  (unit_eq)
    );

    leb_ram #(.WIDTH(8), .DEPTH(LINE_LENGTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared unit operands: step down for the right shift, reach ahead by dist on reads
    // of the left shift, step up otherwise.
    always_comb begin
        unit_b   = CW'(1);
        unit_cmp = cnt_reg;
        unique case (state_reg)
            S_SR_RD, S_SR_WR: begin
                unit_b   = '1;
                unit_cmp = cur_reg;
            end
            S_SL_RD: begin
                unit_b = dist_reg;
            end
            default: begin
                unit_b   = CW'(1);
                unit_cmp = cnt_reg;
            end
        endcase
    end

    assign ram_raddr  = (state_reg == S_SR_RD || state_reg == S_SL_RD) ?
                        unit_sum[AW-1:0] : idx_reg[AW-1:0];
    assign out_free   = !m_valid_reg || m_ready;
    assign len_inc    = len_reg + CW'(1);
    assign chunk_rest = len_reg - cnt_reg;
    assign k          = s_data.key;
    assign s_ready    = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        dist_next   = dist_reg;
        key_next    = key_reg;
        m_data_next = m_data_reg;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    priority if (s_data.end_of_input || (k == KEY_EOF && cur_reg == len_reg)) begin
                        op_next    = OP_EOF;
                        idx_next   = '0;
                        cnt_next   = len_reg;
                        state_next = (len_reg == '0) ? S_TAIL : S_EM_RD;
                    end else if (k >= KEY_PRINT_LO && k <= KEY_PRINT_HI) begin
                        key_next   = k;
                        idx_next   = len_reg;
                        state_next = (len_reg != cur_reg) ? S_SR_RD : S_INS;
                    end else if (k == KEY_LEFT && cur_reg != '0) begin
                        cur_next = cur_reg - CW'(1);
                    end else if (k == KEY_RIGHT && cur_reg != len_reg) begin
                        cur_next = cur_reg + CW'(1);
                    end else if (k == KEY_KILL) begin
                        len_next = cur_reg;
                    end else if (k == KEY_EOF) begin
                        // delete at cursor: pull the tail down by one
                        len_next   = len_reg - CW'(1);
                        idx_next   = cur_reg;
                        dist_next  = CW'(1);
                        cnt_next   = len_reg - CW'(1);
                        state_next = (cur_reg == len_reg - CW'(1)) ? S_IDLE : S_SL_RD;
                    end else if ((k == KEY_BS || k == KEY_DEL) && cur_reg != '0) begin
                        len_next   = len_reg - CW'(1);
                        cur_next   = cur_reg - CW'(1);
                        idx_next   = cur_reg - CW'(1);
                        dist_next  = CW'(1);
                        cnt_next   = len_reg - CW'(1);
                        state_next = (cur_reg == len_reg) ? S_IDLE : S_SL_RD;
                    end else if (k == KEY_NL) begin
                        op_next    = OP_NL;
                        idx_next   = '0;
                        cnt_next   = len_reg;
                        state_next = (len_reg == '0) ? S_TAIL : S_EM_RD;
                    end else if (k == KEY_HOME) begin
                        cur_next = '0;
                    end else if (k == KEY_END) begin
                        cur_next = len_reg;
                    end else begin
                        op_next    = OP_BELL;
                        state_next = S_TAIL;
                    end
                end
            end
            S_SR_RD: begin
                state_next = S_SR_WR;
            end
            S_SR_WR: begin
                ram_we     = 1'b1;
                idx_next   = unit_sum;
                state_next = unit_eq ? S_INS : S_SR_RD;
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[AW-1:0];
                ram_wdata = key_reg;
                len_next  = len_inc;
                cur_next  = cur_reg + CW'(1);
                if (len_inc == cap) begin
                    // line full: send everything before the cursor
                    op_next    = OP_CHUNK;
                    idx_next   = '0;
                    cnt_next   = cur_reg + CW'(1);
                    state_next = S_EM_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EM_RD: begin
                state_next = S_EM_WR;
            end
            S_EM_WR: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_data_next = '{kind: KIND_LINE, data_byte: ram_rdata,
                                    last: (op_reg == OP_CHUNK) && unit_eq};
                    idx_next    = unit_sum;
                    if (!unit_eq) begin
                        state_next = S_EM_RD;
                    end else if (op_reg == OP_CHUNK) begin
                        // shift the rest of the line down over the sent chunk
                        len_next   = chunk_rest;
                        cur_next   = '0;
                        idx_next   = '0;
                        dist_next  = cnt_reg;
                        cnt_next   = chunk_rest;
                        state_next = (chunk_rest == '0) ? S_IDLE : S_SL_RD;
                    end else begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (op_reg)
                        OP_EOF:  m_data_next = '{kind: KIND_END, data_byte: 8'h00, last: 1'b1};
                        OP_NL:   m_data_next = '{kind: KIND_LINE, data_byte: KEY_NL, last: 1'b1};
                        OP_CHUNK, OP_BELL:
                                 m_data_next = '{kind: KIND_BELL, data_byte: 8'h00, last: 1'b1};
                        default: m_data_next = '{kind: KIND_BELL, data_byte: 8'h00, last: 1'b1};
                    endcase
                    if (op_reg == OP_EOF || op_reg == OP_NL) begin
                        len_next = '0;
                        cur_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SL_RD: begin
                state_next = S_SL_WR;
            end
            S_SL_WR: begin
                ram_we     = 1'b1;
                idx_next   = unit_sum;
                state_next = unit_eq ? S_IDLE : S_SL_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // register write drops the line
        if (cfg_clear) begin
            len_next = '0;
            cur_next = '0;
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            dist_reg    <= dist_next;
            key_reg     <= key_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor beyond end of line");

    a_room_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (len_reg < cap))
        else $error("line not below capacity while idle");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EM_WR) |-> (idx_reg < cnt_reg))
        else $error("emit index past count");
`endif

endmodule

// ===== src/line_editor_buffer.sv =====
`timescale 1ns / 1ps
// An insert moves the n-c bytes behind the cursor up by one (n text length, c cursor),
// with one read and one write per moved byte on the store's ports. Sending a line or
// chunk reads each byte and waits while the sink holds off; a delete or the shift after
// a chunk does one read and one write per moved byte.
// Reset is synchronous and active low: it clears length, cursor and reserved_length;
// the store contents stay undefined until written.
module line_editor_buffer #(
    parameter int unsigned LINE_LENGTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  leb_pkg::leb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output leb_pkg::leb_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import leb_pkg::*;

    localparam int unsigned CW        = $clog2(LINE_LENGTH + 1);
    localparam logic [6:0]  LINE_LEN7 = 7'(LINE_LENGTH);

    logic [RL_W-1:0] rl_reg, rl_next;
    logic            cfg_wr;
    logic [6:0]      pl7, cap7;
    logic [CW-1:0]   cap;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RESERVED_LENGTH);
    assign rl_next = cfg_wr ? pwdata[RL_W-1:0] : rl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rl_reg <= '0;
        end else begin
            rl_reg <= rl_next;
        end
    end

    assign prdata = (paddr[2] == REG_RESERVED_LENGTH) ? {{(32-RL_W){1'b0}}, rl_reg} : 32'h0;

    // a prompt as long as the line or longer counts as none
    assign pl7  = ({1'b0, rl_reg} >= LINE_LEN7) ? 7'd0 : {1'b0, rl_reg};
    assign cap7 = LINE_LEN7 - pl7;
    assign cap  = cap7[CW-1:0];

    leb_seq #(.LINE_LENGTH(LINE_LENGTH)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_clear (cfg_wr),
        .cap       (cap)
    );

endmodule
